// ===== rtl/tlt_pkg.sv =====
package tlt_pkg;

  // Table geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Average divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_RESTART = 3'd1,
    ST_FULL    = 3'd2,
    ST_ENDED   = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  // Classified event handed from the front to the back
  typedef struct packed {
    status_e     status;
    logic [63:0] duration;
  } cmd_t;

endpackage

// ===== rtl/txn_event_if.sv =====
interface txn_event_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] txn_id;
  logic [63:0] now_ns;

  modport source (output valid, output op, output txn_id, output now_ns, input ready);
  modport sink   (input valid, input op, input txn_id, input now_ns, output ready);
endinterface

// ===== rtl/txn_result_if.sv =====
interface txn_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] duration;
  logic [31:0] completed_count;
  logic [63:0] average;

  modport source (output valid, output status, output duration, output completed_count,
                  output average, input ready);
  modport sink   (input valid, input status, input duration, input completed_count,
                  input average, output ready);
endinterface

// ===== rtl/tlt_front.sv =====
module tlt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  txn_event_if.sink     evt_i,
  output logic          push_o,
  output tlt_pkg::cmd_t push_data_o,
  input  logic          full_i
);
  import tlt_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MATCH,
    F_PUSH
  } state_e;

  state_e             state_q;
  logic               op_q;
  logic [63:0]        id_q;
  logic [63:0]        now_q;
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic               free_any_q;
  logic [IDX_W-1:0]   free_idx_q;

  logic [ENTRIES-1:0] slot_valid_q;
  logic [63:0]        slot_id_q    [ENTRIES];
  logic [63:0]        slot_start_q [ENTRIES];

  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_any;
  logic [IDX_W-1:0]   free_idx;
  logic [63:0]        start_sel;

  assign evt_i.ready = (state_q == F_IDLE);

  // Search the table: lowest matching valid slot, lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid_q[i] && (slot_id_q[i] == id_q)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!slot_valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Classify the event and measure the duration
  assign start_sel = slot_start_q[hit_idx_q];

  always_comb begin
    push_data_o.duration = '0;
    if (!op_q) begin
      if (hit_q) begin
        push_data_o.status = ST_RESTART;
      end else if (free_any_q) begin
        push_data_o.status = ST_NEW;
      end else begin
        push_data_o.status = ST_FULL;
      end
    end else begin
      if (hit_q) begin
        push_data_o.status   = ST_ENDED;
        push_data_o.duration = now_q - start_sel;
      end else begin
        push_data_o.status = ST_UNKNOWN;
      end
    end
  end

  assign push_o = (state_q == F_PUSH) && !full_i;

  // Sequence: take word, search, then update table and hand off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      slot_valid_q <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (evt_i.valid) begin
            state_q <= F_MATCH;
          end
        end
        F_MATCH: begin
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (push_o) begin
            state_q <= F_IDLE;
            if (!op_q) begin
              if (!hit_q && free_any_q) begin
                slot_valid_q[free_idx_q] <= 1'b1;
              end
            end else if (hit_q) begin
              slot_valid_q[hit_idx_q] <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  // Latch the event and search results; write slot payload
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      op_q  <= evt_i.op;
      id_q  <= evt_i.txn_id;
      now_q <= evt_i.now_ns;
    end
    if (state_q == F_MATCH) begin
      hit_q      <= hit_any;
      hit_idx_q  <= hit_idx;
      free_any_q <= free_any;
      free_idx_q <= free_idx;
    end
    if (push_o && !op_q) begin
      if (hit_q) begin
        slot_start_q[hit_idx_q] <= now_q;
      end else if (free_any_q) begin
        slot_id_q[free_idx_q]    <= id_q;
        slot_start_q[free_idx_q] <= now_q;
      end
    end
  end

endmodule

// ===== rtl/tlt_fifo.sv =====
module tlt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tlt_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output tlt_pkg::cmd_t pop_data_o,
  output logic          empty_o
);
  import tlt_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    ptr_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/tlt_back.sv =====
module tlt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  tlt_pkg::cmd_t pop_data_i,
  output logic          pop_o,
  txn_result_if.source  res_o
);
  import tlt_pkg::*;

  typedef enum logic {
    B_IDLE,
    B_DIV
  } state_e;

  state_e               state_q;
  logic [31:0]          count_q;
  logic [63:0]          sum_q;
  logic [63:0]          avg_q;
  logic [31:0]          rem_q;
  logic [63:0]          quo_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic [63:0]          dur_q;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [63:0]          out_dur_q;
  logic [31:0]          out_count_q;
  logic [63:0]          out_avg_q;

  logic                 out_free;
  logic                 out_load;
  logic                 div_last;
  logic [31:0]          count_inc;
  logic [64:0]          sum_add;
  logic [63:0]          sum_new;
  logic [32:0]          shifted;
  logic [32:0]          diff;
  logic                 ge;
  logic [31:0]          rem_next;
  logic [63:0]          quo_next;

  assign out_free = !out_valid_q || res_o.ready;
  assign pop_o    = (state_q == B_IDLE) && !empty_i && out_free;

  // Load the result word on a plain command or at the last divide step
  assign div_last = (state_q == B_DIV) && (step_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_load = (pop_o && (pop_data_i.status != ST_ENDED)) || div_last;

  // Saturating count and sum
  assign count_inc = (count_q == 32'hFFFF_FFFF) ? count_q : count_q + 32'd1;
  assign sum_add   = {1'b0, sum_q} + {1'b0, pop_data_i.duration};
  assign sum_new   = sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];

  // One restoring division step; remainder stays below the 32-bit count
  assign shifted  = {rem_q, quo_q[63]};
  assign diff     = shifted - {1'b0, count_q};
  assign ge       = (shifted >= {1'b0, count_q});
  assign rem_next = ge ? diff[31:0] : shifted[31:0];
  assign quo_next = {quo_q[62:0], ge};

  assign res_o.valid           = out_valid_q;
  assign res_o.status          = out_status_q;
  assign res_o.duration        = out_dur_q;
  assign res_o.completed_count = out_count_q;
  assign res_o.average         = out_avg_q;

  // Sequence: take a command, update totals, divide, present the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      count_q      <= '0;
      sum_q        <= '0;
      avg_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      step_q       <= '0;
      dur_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_NEW;
      out_dur_q    <= '0;
      out_count_q  <= '0;
      out_avg_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (pop_data_i.status == ST_ENDED) begin
              count_q <= count_inc;
              sum_q   <= sum_new;
              rem_q   <= '0;
              quo_q   <= sum_new;
              step_q  <= '0;
              dur_q   <= pop_data_i.duration;
              state_q <= B_DIV;
            end else begin
              out_status_q <= pop_data_i.status;
              out_dur_q    <= pop_data_i.duration;
              out_count_q  <= count_q;
              out_avg_q    <= avg_q;
            end
          end
        end
        B_DIV: begin
          rem_q  <= rem_next;
          quo_q  <= quo_next;
          step_q <= step_q + 1'b1;
          if (div_last) begin
            avg_q        <= quo_next;
            out_status_q <= ST_ENDED;
            out_dur_q    <= dur_q;
            out_count_q  <= count_q;
            out_avg_q    <= quo_next;
            state_q      <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/transaction_latency_tracker.sv =====
// Transaction latency tracker.
// evt_i carries one event word per transaction start or end (op, txn_id, now_ns);
// res_o returns exactly one result word per event, in event order: status,
// duration of an ended transaction, completed count and running average.
// A 16-slot table holds the outstanding ids with their start times.
// The front takes an event, searches the table and updates it (states F_IDLE,
// F_MATCH, F_PUSH), then posts a command into a two-word queue. The back turns
// each command into a result word: directly for starts and unknown ends, and
// for a matched end through the 64-step radix-2 divider that recomputes the
// average. The front takes a new event only after it has handed off the
// previous one; the back takes no new command while it divides.
// Reset empties the table and clears count, sum and average; the front is
// ready for events once reset is released.
// When the receiver stalls, the result word holds on res_o; the back stops,
// the queue fills, and then the front stops taking events.
module transaction_latency_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  txn_event_if.sink     evt_i,
  txn_result_if.source  res_o
);
  import tlt_pkg::*;

  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  cmd_t pop_data;
  logic empty;

  tlt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  tlt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  tlt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule
